// ===== rtl/core/polar_line_intersect_macros.svh =====
// polar_line_intersect_macros.svh: assertion macros for the polar line intersection core
// used by polar_line_intersect.sv and pli_div_cell.sv; no other dependencies
// defining NO_ASSERTIONS turns every macro into an empty body
`ifndef POLAR_LINE_INTERSECT_MACROS_SVH
`define POLAR_LINE_INTERSECT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked outside reset
`define PLI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");
// next-cycle implication, checked outside reset
`define PLI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define PLI_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PLI_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/core/pli_pkg.sv =====
// pli_pkg.sv: types, constants and angle/sine helpers of the polar line intersection core
// no dependencies; imported by every module of the core
`default_nettype none

package pli_pkg;

    // default widths
    localparam int RADIUS_BITS_DEF    = 14;
    localparam int SINE_FRAC_BITS_DEF = 15;
    localparam int THETA_W            = 9;
    localparam int POINT_W            = 32;

    // quarter-wave sine table, whole degrees 0..90
    localparam int QUARTER_N = 91;
    localparam int QIDX_W    = $clog2(QUARTER_N);

    // pi in Q30
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef logic [THETA_W-1:0] angle_t;

    localparam angle_t DEG_90  = 9'd90;
    localparam angle_t DEG_180 = 9'd180;
    localparam angle_t DEG_270 = 9'd270;
    localparam angle_t DEG_360 = 9'd360;
    localparam angle_t DEG_450 = 9'd450;

    // control bits that travel with an item down the divider chain
    typedef struct packed {
        logic valid;
        logic par;
        logic neg_x;
        logic neg_y;
    } pli_ctl_t;

    // one finished result item
    typedef struct packed {
        logic               clip;
        logic               par;
        logic [POINT_W-1:0] py;
        logic [POINT_W-1:0] px;
    } pli_res_t;

    // phi = (90 - theta) mod 360, theta first taken mod 360
    function automatic angle_t phi_of_theta(input angle_t theta);
        angle_t t;
        t = (theta >= DEG_360) ? theta - DEG_360 : theta;
        return (t <= DEG_90) ? DEG_90 - t : DEG_450 - t;
    endfunction

    // angle of the cosine: (p + 90) mod 360
    function automatic angle_t cos_angle(input angle_t p);
        return (p >= DEG_270) ? p - DEG_270 : p + DEG_90;
    endfunction

    // (pb - pa) mod 360; the 9-bit wrap gives the right value below 512
    function automatic angle_t diff_angle(input angle_t pa, input angle_t pb);
        return (pb >= pa) ? pb - pa : pb + DEG_360 - pa;
    endfunction

    // sine of whole degree d (0..90) by Taylor series in Q30, rounded to frac bits
    function automatic longint unsigned sine_q(input int unsigned d, input int unsigned frac);
        longint unsigned x;
        longint unsigned term;
        longint unsigned prod;
        longint unsigned v;
        longint          sum;
        int              k;
        if (d >= 90) begin
            v = 64'd1 << 30;
        end else begin
            x    = (longint'(d) * PI_Q30 + 64'd90) / 64'd180;
            sum  = longint'(x);
            term = x;
            for (k = 1; k < 16; k++) begin
                if (term != 64'd0) begin
                    prod = (term * x) >> 30;
                    prod = (prod * x) >> 30;
                    case (k)
                        1:       term = prod / 64'd6;
                        2:       term = prod / 64'd20;
                        3:       term = prod / 64'd42;
                        4:       term = prod / 64'd72;
                        5:       term = prod / 64'd110;
                        6:       term = prod / 64'd156;
                        7:       term = prod / 64'd210;
                        8:       term = prod / 64'd272;
                        9:       term = prod / 64'd342;
                        10:      term = prod / 64'd420;
                        11:      term = prod / 64'd506;
                        12:      term = prod / 64'd600;
                        13:      term = prod / 64'd702;
                        14:      term = prod / 64'd812;
                        default: term = prod / 64'd930;
                    endcase
                    if (k[0]) begin
                        sum = sum - longint'(term);
                    end else begin
                        sum = sum + longint'(term);
                    end
                end
            end
            v = longint'(sum);
        end
        if (frac < 30) begin
            v = (v + (64'd1 << (29 - frac))) >> (30 - frac);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/polar_line_intersect.sv =====
// polar_line_intersect.sv: top level of the Hough line intersection core
// uses pli_pkg, pli_front, pli_div_cell and the assertion macros
//
// channel   dir  ports                       fields, lowest bit first
// s_        in   s_tvalid s_tready s_tdata   theta_a, r_a, theta_b, r_b, zero pad to bytes
// m_        out  m_tvalid m_tready m_tdata   point_x, point_y
//                m_tuser                     parallel, clipped
//
// one item per cycle while the skid register is empty; an accepted item passes the
// front stages, the divider chain and the output register before m_tvalid shows it
// the divider chain has one quotient bit per cell and one cell per numerator bit
// reset clears only valid and control bits; there is no memory to clear
// an output register plus a skid register absorb a stalled m_tready; s_tready drops
// only while the skid holds an item, and then the whole pipeline holds
`default_nettype none

`include "polar_line_intersect_macros.svh"

module polar_line_intersect
    import pli_pkg::*;
#(
    parameter int RADIUS_BITS    = RADIUS_BITS_DEF,
    parameter int SINE_FRAC_BITS = SINE_FRAC_BITS_DEF
) (
    input  wire                                                       aclk,
    input  wire                                                       aresetn,
    input  wire                                                       s_tvalid,
    output logic                                                      s_tready,
    // theta_a, r_a, theta_b, r_b, zero pad
    input  wire logic [((2*THETA_W+2*RADIUS_BITS+7)/8)*8-1:0]         s_tdata,
    output logic                                                      m_tvalid,
    input  wire                                                       m_tready,
    // point_x, point_y
    output logic [2*POINT_W-1:0]                                      m_tdata,
    // parallel, clipped
    output logic [1:0]                                                m_tuser
);

    localparam int NPW = RADIUS_BITS + SINE_FRAC_BITS + 2;
    localparam int DPW = SINE_FRAC_BITS + 2;
    localparam int QXW = (NPW > POINT_W + 1) ? NPW : POINT_W + 1;

    angle_t                        theta_a, theta_b;
    logic signed [RADIUS_BITS-1:0] r_a, r_b;
    logic                          adv;
    logic                          in_fire;

    pli_ctl_t       ctl_link   [NPW+1];
    logic [DPW-1:0] den_link   [NPW+1];
    logic [DPW-1:0] rem_x_link [NPW+1];
    logic [DPW-1:0] rem_y_link [NPW+1];
    logic [NPW-1:0] num_x_link [NPW+1];
    logic [NPW-1:0] num_y_link [NPW+1];

    logic [POINT_W:0] sat_x, sat_y;
    pli_res_t         res_next;
    pli_res_t         out_reg, skid_reg;
    logic             m_vld_reg, m_vld_next;
    logic             skid_vld_reg, skid_vld_next;
    logic             load_from_pipe, load_from_skid, load_skid;
    logic             pipe_vld;

    // sign and saturation of an already rounded unsigned quotient: {clip, value}
    function automatic logic [POINT_W:0] sat_point(input logic [QXW-1:0] q, input logic neg);
        logic [QXW-1:0] lim_pos;
        logic [QXW-1:0] lim_neg;
        logic [QXW-1:0] nq;
        lim_pos = QXW'(32'h7FFF_FFFF);
        lim_neg = QXW'(33'h0_8000_0000);
        nq      = '0 - q;
        if (neg) begin
            if (q > lim_neg) begin
                return {1'b1, 32'h8000_0000};
            end
            return {1'b0, nq[POINT_W-1:0]};
        end
        if (q > lim_pos) begin
            return {1'b1, 32'h7FFF_FFFF};
        end
        return {1'b0, q[POINT_W-1:0]};
    endfunction

    // input unpacking
    assign theta_a = s_tdata[THETA_W-1:0];
    assign r_a     = s_tdata[THETA_W +: RADIUS_BITS];
    assign theta_b = s_tdata[THETA_W+RADIUS_BITS +: THETA_W];
    assign r_b     = s_tdata[2*THETA_W+RADIUS_BITS +: RADIUS_BITS];

    // pipeline moves whenever the skid is free
    assign adv      = ~skid_vld_reg;
    assign s_tready = adv;
    assign in_fire  = s_tvalid & s_tready;

    pli_front #(
        .RADIUS_BITS   (RADIUS_BITS),
        .SINE_FRAC_BITS(SINE_FRAC_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .in_valid(in_fire),
        .theta_a (theta_a),
        .r_a     (r_a),
        .theta_b (theta_b),
        .r_b     (r_b),
        .ctl_out (ctl_link[0]),
        .num_x   (num_x_link[0]),
        .num_y   (num_y_link[0]),
        .den     (den_link[0])
    );

    assign rem_x_link[0] = '0;
    assign rem_y_link[0] = '0;

    // divider chain, one cell per numerator bit
    for (genvar i = 0; i < NPW; i++) begin : g_cell
        pli_div_cell #(
            .RADIUS_BITS   (RADIUS_BITS),
            .SINE_FRAC_BITS(SINE_FRAC_BITS)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .ctl_in   (ctl_link[i]),
            .den_in   (den_link[i]),
            .rem_x_in (rem_x_link[i]),
            .num_x_in (num_x_link[i]),
            .rem_y_in (rem_y_link[i]),
            .num_y_in (num_y_link[i]),
            .ctl_out  (ctl_link[i+1]),
            .den_out  (den_link[i+1]),
            .rem_x_out(rem_x_link[i+1]),
            .num_x_out(num_x_link[i+1]),
            .rem_y_out(rem_y_link[i+1]),
            .num_y_out(num_y_link[i+1])
        );
    end

    // sign, saturation and the parallel case
    always_comb begin
        sat_x = sat_point(QXW'(num_x_link[NPW]), ctl_link[NPW].neg_x);
        sat_y = sat_point(QXW'(num_y_link[NPW]), ctl_link[NPW].neg_y);
        if (ctl_link[NPW].par) begin
            res_next.px   = '0;
            res_next.py   = '0;
            res_next.par  = 1'b1;
            res_next.clip = 1'b0;
        end else begin
            res_next.px   = sat_x[POINT_W-1:0];
            res_next.py   = sat_y[POINT_W-1:0];
            res_next.par  = 1'b0;
            res_next.clip = sat_x[POINT_W] | sat_y[POINT_W];
        end
    end

    assign pipe_vld = ctl_link[NPW].valid;

    // output register and skid control
    always_comb begin
        m_vld_next     = m_vld_reg;
        skid_vld_next  = skid_vld_reg;
        load_from_pipe = 1'b0;
        load_from_skid = 1'b0;
        load_skid      = 1'b0;
        if (skid_vld_reg) begin
            if (m_tready) begin
                skid_vld_next  = 1'b0;
                load_from_skid = 1'b1;
            end
        end else if (pipe_vld) begin
            if (!m_vld_reg || m_tready) begin
                m_vld_next     = 1'b1;
                load_from_pipe = 1'b1;
            end else begin
                skid_vld_next = 1'b1;
                load_skid     = 1'b1;
            end
        end else if (m_tready) begin
            m_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg    <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            m_vld_reg    <= m_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_from_skid) begin
            out_reg <= skid_reg;
        end else if (load_from_pipe) begin
            out_reg <= res_next;
        end
        if (load_skid) begin
            skid_reg <= res_next;
        end
    end

    // result ports
    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {out_reg.py, out_reg.px};
    assign m_tuser  = {out_reg.clip, out_reg.par};

    // a held skid item always sits behind a shown item
    `PLI_ASSERT_IMP(a_skid_behind_out, aclk, aresetn, skid_vld_reg, m_tvalid)
    // a parallel result carries zero coordinates and no clip
    `PLI_ASSERT_IMP(a_parallel_clean, aclk, aresetn, m_tvalid && m_tuser[0], !m_tuser[1] && (m_tdata == '0))
    // the skid is not dropped while the output is stalled
    `PLI_ASSERT_NXT(a_skid_kept, aclk, aresetn, skid_vld_reg && !m_tready, skid_vld_reg)

endmodule

`default_nettype wire

// ===== rtl/core/pli_sine_lut.sv =====
// pli_sine_lut.sv: registered sine lookup for a whole-degree angle 0..359
// quarter-wave constant table folded by quadrant; uses pli_pkg
`default_nettype none

module pli_sine_lut
    import pli_pkg::*;
#(
    parameter int SINE_FRAC_BITS = SINE_FRAC_BITS_DEF
) (
    input  wire                              aclk,
    input  wire                              en,
    input  wire angle_t                      angle,
    output logic signed [SINE_FRAC_BITS+1:0] sine
);

    localparam int MW = SINE_FRAC_BITS + 1;
    localparam int SW = SINE_FRAC_BITS + 2;

    logic [MW-1:0]        quarter [QUARTER_N];
    angle_t               fold;
    logic                 neg;
    logic [MW-1:0]        mag;
    logic signed [SW-1:0] sine_reg;
    logic signed [SW-1:0] sine_next;

    // constant quarter-wave table
    for (genvar i = 0; i < QUARTER_N; i++) begin : g_quarter
        localparam logic [MW-1:0] QV = MW'(sine_q(i, SINE_FRAC_BITS));
        assign quarter[i] = QV;
    end

    // quadrant fold and signed lookup
    always_comb begin
        neg  = 1'b0;
        fold = angle;
        if (angle <= DEG_90) begin
            fold = angle;
        end else if (angle <= DEG_180) begin
            fold = DEG_180 - angle;
        end else if (angle <= DEG_270) begin
            fold = angle - DEG_180;
            neg  = 1'b1;
        end else begin
            fold = DEG_360 - angle;
            neg  = 1'b1;
        end
        mag       = quarter[fold[QIDX_W-1:0]];
        sine_next = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sine_reg <= sine_next;
        end
    end

    assign sine = sine_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pli_front.sv =====
// pli_front.sv: six-stage front end: angles, sine lookups, Cramer products and
// divider operands (2|n| + |d| over 2|d|); uses pli_pkg and pli_sine_lut
`default_nettype none

module pli_front
    import pli_pkg::*;
#(
    parameter int RADIUS_BITS    = RADIUS_BITS_DEF,
    parameter int SINE_FRAC_BITS = SINE_FRAC_BITS_DEF
) (
    input  wire                                            aclk,
    input  wire                                            aresetn,
    input  wire                                            en,
    input  wire                                            in_valid,
    input  wire angle_t                                    theta_a,
    input  wire logic signed [RADIUS_BITS-1:0]             r_a,
    input  wire angle_t                                    theta_b,
    input  wire logic signed [RADIUS_BITS-1:0]             r_b,
    output pli_ctl_t                                       ctl_out,
    output logic [RADIUS_BITS+SINE_FRAC_BITS+1:0]          num_x,
    output logic [RADIUS_BITS+SINE_FRAC_BITS+1:0]          num_y,
    output logic [SINE_FRAC_BITS+1:0]                      den
);

    localparam int SW   = SINE_FRAC_BITS + 2;
    localparam int PW   = RADIUS_BITS + SINE_FRAC_BITS + 2;
    localparam int AW   = PW - 1;
    localparam int DAW  = SINE_FRAC_BITS + 1;
    localparam int DPW  = SINE_FRAC_BITS + 2;
    localparam int NSTG = 6;

    logic [NSTG-1:0] vld_reg, vld_next;

    // stage 1: line angles
    angle_t pa_reg, pb_reg, pa_next, pb_next;
    logic signed [RADIUS_BITS-1:0] ra1_reg, rb1_reg;

    // stage 2: the five lookup angles
    angle_t ang_sa_reg, ang_ca_reg, ang_sb_reg, ang_cb_reg, ang_d_reg;
    angle_t ang_ca_next, ang_cb_next, ang_d_next;
    logic signed [RADIUS_BITS-1:0] ra2_reg, rb2_reg;

    // stage 3: sines (registered in the lookups)
    logic signed [SW-1:0] sa, ca, sb, cb, dv;
    logic signed [RADIUS_BITS-1:0] ra3_reg, rb3_reg;

    // stage 4: products
    logic signed [PW-1:0] asb_reg, bsa_reg, bca_reg, acb_reg;
    logic signed [PW-1:0] asb_next, bsa_next, bca_next, acb_next;
    logic signed [SW-1:0] d4_reg;

    // stage 5: numerators
    logic signed [PW-1:0] nx5_reg, ny5_reg, nx5_next, ny5_next;
    logic signed [SW-1:0] d5_reg;

    // stage 6: divider operands
    logic [AW-1:0]  absx, absy;
    logic [DAW-1:0] absd;
    logic [PW-1:0]  nx6_reg, ny6_reg, nx6_next, ny6_next;
    logic [DPW-1:0] den6_reg, den6_next;
    logic           negx6_reg, negy6_reg, par6_reg;
    logic           negx6_next, negy6_next, par6_next;

    // item valid bits, one per stage
    assign vld_next = {vld_reg[NSTG-2:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // stage logic
    always_comb begin
        pa_next     = phi_of_theta(theta_a);
        pb_next     = phi_of_theta(theta_b);
        ang_ca_next = cos_angle(pa_reg);
        ang_cb_next = cos_angle(pb_reg);
        ang_d_next  = diff_angle(pa_reg, pb_reg);
        asb_next    = PW'(ra3_reg) * PW'(sb);
        bsa_next    = PW'(rb3_reg) * PW'(sa);
        bca_next    = PW'(rb3_reg) * PW'(ca);
        acb_next    = PW'(ra3_reg) * PW'(cb);
        nx5_next    = asb_reg - bsa_reg;
        ny5_next    = bca_reg - acb_reg;
        absx        = AW'(nx5_reg[PW-1] ? -nx5_reg : nx5_reg);
        absy        = AW'(ny5_reg[PW-1] ? -ny5_reg : ny5_reg);
        absd        = DAW'(d5_reg[SW-1] ? -d5_reg : d5_reg);
        nx6_next    = {absx, 1'b0} + PW'(absd);
        ny6_next    = {absy, 1'b0} + PW'(absd);
        den6_next   = {absd, 1'b0};
        negx6_next  = nx5_reg[PW-1] ^ d5_reg[SW-1];
        negy6_next  = ny5_reg[PW-1] ^ d5_reg[SW-1];
        par6_next   = (d5_reg == '0);
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg     <= pa_next;
            pb_reg     <= pb_next;
            ra1_reg    <= r_a;
            rb1_reg    <= r_b;
            ang_sa_reg <= pa_reg;
            ang_sb_reg <= pb_reg;
            ang_ca_reg <= ang_ca_next;
            ang_cb_reg <= ang_cb_next;
            ang_d_reg  <= ang_d_next;
            ra2_reg    <= ra1_reg;
            rb2_reg    <= rb1_reg;
            ra3_reg    <= ra2_reg;
            rb3_reg    <= rb2_reg;
            asb_reg    <= asb_next;
            bsa_reg    <= bsa_next;
            bca_reg    <= bca_next;
            acb_reg    <= acb_next;
            d4_reg     <= dv;
            nx5_reg    <= nx5_next;
            ny5_reg    <= ny5_next;
            d5_reg     <= d4_reg;
            nx6_reg    <= nx6_next;
            ny6_reg    <= ny6_next;
            den6_reg   <= den6_next;
            negx6_reg  <= negx6_next;
            negy6_reg  <= negy6_next;
            par6_reg   <= par6_next;
        end
    end

    // sine lookups
    pli_sine_lut #(.SINE_FRAC_BITS(SINE_FRAC_BITS)) u_lut_sa (
        .aclk(aclk), .en(en), .angle(ang_sa_reg), .sine(sa)
    );
    pli_sine_lut #(.SINE_FRAC_BITS(SINE_FRAC_BITS)) u_lut_ca (
        .aclk(aclk), .en(en), .angle(ang_ca_reg), .sine(ca)
    );
    pli_sine_lut #(.SINE_FRAC_BITS(SINE_FRAC_BITS)) u_lut_sb (
        .aclk(aclk), .en(en), .angle(ang_sb_reg), .sine(sb)
    );
    pli_sine_lut #(.SINE_FRAC_BITS(SINE_FRAC_BITS)) u_lut_cb (
        .aclk(aclk), .en(en), .angle(ang_cb_reg), .sine(cb)
    );
    pli_sine_lut #(.SINE_FRAC_BITS(SINE_FRAC_BITS)) u_lut_d (
        .aclk(aclk), .en(en), .angle(ang_d_reg), .sine(dv)
    );

    // hand-off to the divider chain
    always_comb begin
        ctl_out.valid = vld_reg[NSTG-1];
        ctl_out.par   = par6_reg;
        ctl_out.neg_x = negx6_reg;
        ctl_out.neg_y = negy6_reg;
    end

    assign num_x = nx6_reg;
    assign num_y = ny6_reg;
    assign den   = den6_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pli_div_cell.sv =====
// pli_div_cell.sv: one cell of the restoring divider chain, one quotient bit per
// lane (x and y share the divisor); uses pli_pkg and the assertion macros
`default_nettype none

`include "polar_line_intersect_macros.svh"

module pli_div_cell
    import pli_pkg::*;
#(
    parameter int RADIUS_BITS    = RADIUS_BITS_DEF,
    parameter int SINE_FRAC_BITS = SINE_FRAC_BITS_DEF
) (
    input  wire                                       aclk,
    input  wire                                       aresetn,
    input  wire                                       en,
    input  wire pli_ctl_t                             ctl_in,
    input  wire logic [SINE_FRAC_BITS+1:0]            den_in,
    input  wire logic [SINE_FRAC_BITS+1:0]            rem_x_in,
    input  wire logic [RADIUS_BITS+SINE_FRAC_BITS+1:0] num_x_in,
    input  wire logic [SINE_FRAC_BITS+1:0]            rem_y_in,
    input  wire logic [RADIUS_BITS+SINE_FRAC_BITS+1:0] num_y_in,
    output pli_ctl_t                                  ctl_out,
    output logic [SINE_FRAC_BITS+1:0]                 den_out,
    output logic [SINE_FRAC_BITS+1:0]                 rem_x_out,
    output logic [RADIUS_BITS+SINE_FRAC_BITS+1:0]     num_x_out,
    output logic [SINE_FRAC_BITS+1:0]                 rem_y_out,
    output logic [RADIUS_BITS+SINE_FRAC_BITS+1:0]     num_y_out
);

    localparam int NPW = RADIUS_BITS + SINE_FRAC_BITS + 2;
    localparam int DPW = SINE_FRAC_BITS + 2;

    logic [DPW:0]   trial_x, trial_y;
    logic           fit_x, fit_y;
    pli_ctl_t       ctl_reg;
    logic [DPW-1:0] den_reg;
    logic [DPW-1:0] rem_x_reg, rem_y_reg, rem_x_next, rem_y_next;
    logic [NPW-1:0] num_x_reg, num_y_reg, num_x_next, num_y_next;

    // shift in the next numerator bit, subtract when the divisor fits
    always_comb begin
        trial_x    = {rem_x_in, num_x_in[NPW-1]};
        trial_y    = {rem_y_in, num_y_in[NPW-1]};
        fit_x      = (trial_x >= {1'b0, den_in});
        fit_y      = (trial_y >= {1'b0, den_in});
        rem_x_next = DPW'(fit_x ? trial_x - {1'b0, den_in} : trial_x);
        rem_y_next = DPW'(fit_y ? trial_y - {1'b0, den_in} : trial_y);
        num_x_next = {num_x_in[NPW-2:0], fit_x};
        num_y_next = {num_y_in[NPW-2:0], fit_y};
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg   <= den_in;
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
            num_x_reg <= num_x_next;
            num_y_reg <= num_y_next;
        end
    end

    assign ctl_out   = ctl_reg;
    assign den_out   = den_reg;
    assign rem_x_out = rem_x_reg;
    assign num_x_out = num_x_reg;
    assign rem_y_out = rem_y_reg;
    assign num_y_out = num_y_reg;

    // partial remainders stay below the divisor for a real item
    `PLI_ASSERT_IMP(a_rem_below_den, aclk, aresetn, ctl_reg.valid && !ctl_reg.par, (rem_x_reg < den_reg) && (rem_y_reg < den_reg))

endmodule

`default_nettype wire

// ===== tb/tb_polar_line_intersect.sv =====
`timescale 1ns / 1ps
// tb_polar_line_intersect.sv: self-checking bench for the Hough line intersection core
// needs pli_pkg and polar_line_intersect; predicts every point from its own sine lookup
// and checks each output item field by field under random idling on both channels

module tb_polar_line_intersect;
    import pli_pkg::*;

    localparam int RAD_W    = 14;
    localparam int DATA_W   = 48;
    localparam int DRAIN    = 60;     // covers the pipeline depth plus output skid
    localparam int N_RANDOM = 850;
    localparam int CALM_TAIL = 100;   // last items run with no idling
    localparam longint unsigned PI_FIXED30 = 64'd3373259426;

    // one predicted output item
    typedef struct packed {
        logic signed [POINT_W-1:0] x;
        logic signed [POINT_W-1:0] y;
        logic                      par;
        logic                      clip;
    } isect_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_tvalid = 1'b0;
    wire                       s_tready;
    // theta_a, r_a, theta_b, r_b, zero pad
    logic [DATA_W-1:0]         s_tdata = '0;
    wire                       m_tvalid;
    logic                      m_tready = 1'b0;
    // point_x, point_y
    wire  [2*POINT_W-1:0]      m_tdata;
    // parallel, clipped
    wire  [1:0]                m_tuser;

    logic [DATA_W-1:0] pair_queue[$];
    isect_t            exp_points[$];
    int                sin_lut[0:359];
    int                n_queued = 0;
    int                n_accepted = 0;
    int                n_checked = 0;
    int                n_errors = 0;
    int                n_parallel = 0;
    int                n_wrapped = 0;
    int                n_clipped = 0;
    int                gap_cnt = 0;
    int                quiet_s = 0;
    int                stall_cnt = 0;
    int                quiet_m = 0;

    polar_line_intersect dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // first-quadrant sine in Q30, Taylor series until a term vanishes
    function automatic longint quarter_sine_q30(input int unsigned deg);
        longint unsigned x;
        longint unsigned term;
        longint          acc;
        int              k;
        if (deg >= 90) return longint'(1) << 30;
        x    = (64'(deg) * PI_FIXED30 + 64'd90) / 64'd180;
        acc  = longint'(x);
        term = x;
        for (k = 1; k < 16 && term != 0; k++) begin
            term = (term * x) >> 30;
            term = ((term * x) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) acc = acc - longint'(term);
            else acc = acc + longint'(term);
        end
        return acc;
    endfunction

    // full-circle Q1.15 sine by quadrant symmetry
    task automatic build_sin_lut();
        int     d;
        int     a;
        bit     neg;
        longint v;
        for (d = 0; d < 360; d++) begin
            if (d <= 90) begin a = d; neg = 0; end
            else if (d <= 180) begin a = 180 - d; neg = 0; end
            else if (d <= 270) begin a = d - 180; neg = 1; end
            else begin a = 360 - d; neg = 1; end
            v = (quarter_sine_q30(a) + (longint'(1) << 14)) >> 15;
            sin_lut[d] = neg ? -int'(v) : int'(v);
        end
    endtask

    // quotient rounded half away from zero, saturated to 32 bits
    function automatic logic [POINT_W-1:0] round_quot(input longint num, input longint den,
                                                     output bit sat);
        longint unsigned an;
        longint unsigned ad;
        longint unsigned q;
        bit              neg;
        sat = 0;
        an  = (num < 0) ? longint'(-num) : num;
        ad  = (den < 0) ? longint'(-den) : den;
        neg = (num < 0) != (den < 0);
        q   = (2 * an + ad) / (2 * ad);
        if (neg) begin
            if (q > 64'h8000_0000) begin sat = 1; q = 64'h8000_0000; end
            return POINT_W'(-q);
        end
        if (q > 64'h7FFF_FFFF) begin sat = 1; q = 64'h7FFF_FFFF; end
        return POINT_W'(q);
    endfunction

    // Cramer's rule on the two polar lines
    function automatic isect_t solve_intersection(input logic [DATA_W-1:0] word);
        int unsigned ta;
        int unsigned tb;
        int unsigned pa;
        int unsigned pb;
        longint      ra;
        longint      rb;
        longint      dv;
        bit          sat_x;
        bit          sat_y;
        isect_t      p;
        ta = word[8:0] % 360;
        tb = word[31:23] % 360;
        pa = (450 - ta) % 360;
        pb = (450 - tb) % 360;
        ra = $signed(word[22:9]);
        rb = $signed(word[45:32]);
        dv = sin_lut[(pb + 360 - pa) % 360];
        p  = '0;
        if (dv == 0) begin
            p.par = 1'b1;
            return p;
        end
        p.x    = round_quot(ra * sin_lut[pb] - rb * sin_lut[pa], dv, sat_x);
        p.y    = round_quot(rb * sin_lut[(pa + 90) % 360] - ra * sin_lut[(pb + 90) % 360],
                            dv, sat_y);
        p.clip = sat_x | sat_y;
        return p;
    endfunction

    task automatic add_pair(input logic [8:0] ta, input logic [RAD_W-1:0] ra,
                            input logic [8:0] tb, input logic [RAD_W-1:0] rb);
        pair_queue.push_back({2'b00, rb, tb, ra, ta});
    endtask

    function automatic logic [RAD_W-1:0] rand_radius();
        case ($urandom_range(0, 9))
            0:       return 14'h2000;
            1:       return 14'h1FFF;
            2:       return RAD_W'($urandom_range(0, 15)) - 14'd8;
            default: return RAD_W'($urandom_range(0, 16383));
        endcase
    endfunction

    function automatic logic [8:0] rand_theta();
        if ($urandom_range(0, 7) == 0) return 9'($urandom_range(360, 511));
        return 9'($urandom_range(0, 359));
    endfunction

    // same direction, optionally written as an angle at or above 360
    function automatic logic [8:0] alias_angle(input int unsigned t);
        if (t < 152 && $urandom_range(0, 1) == 1) return 9'(t + 360);
        return 9'(t);
    endfunction

    // stimulus: directed corners, then random pairs
    task automatic fill_pairs();
        int i;
        int unsigned ta;
        add_pair(9'd0,   14'd0,      9'd0,   14'd0);
        add_pair(9'd0,   14'd100,    9'd90,  -14'sd50);
        add_pair(9'd45,  14'h1FFF,   9'd135, 14'h2000);
        add_pair(9'd359, 14'h2000,   9'd0,   14'h1FFF);
        add_pair(9'd0,   14'h1FFF,   9'd1,   14'h2000);
        add_pair(9'd180, 14'd10,     9'd0,   14'd20);
        add_pair(9'd360, 14'd5,      9'd90,  14'd7);
        add_pair(9'd511, -14'sd1,    9'd151, 14'd3);
        add_pair(9'd90,  14'd1,      9'd270, 14'd1);
        add_pair(9'd270, 14'h1FFF,   9'd0,   14'h1FFF);
        add_pair(9'd30,  14'd1000,   9'd300, -14'sd1000);
        add_pair(9'd89,  14'h2000,   9'd91,  14'h1FFF);
        add_pair(9'd256, 14'd0,      9'd255, 14'd0);
        add_pair(9'd1,   14'd1,      9'd179, -14'sd1);
        add_pair(9'd360, 14'h1FFF,   9'd0,   14'h2000);
        add_pair(9'd450, 14'd100,    9'd0,   14'd50);
        add_pair(9'd123, 14'd4096,   9'd57,  -14'sd4096);
        add_pair(9'd0,   14'h2000,   9'd270, 14'h2000);
        add_pair(9'd315, 14'd2000,   9'd225, 14'd3000);
        add_pair(9'd511, 14'h2AAA,   9'd256, 14'h1555);
        for (i = 0; i < N_RANDOM; i++) begin
            ta = $urandom_range(0, 359);
            case ($urandom_range(0, 9))
                0:       add_pair(alias_angle(ta), rand_radius(), alias_angle(ta),
                                  rand_radius());
                1:       add_pair(alias_angle(ta), rand_radius(),
                                  alias_angle((ta + 180) % 360), rand_radius());
                2:       add_pair(alias_angle(ta), rand_radius(),
                                  alias_angle((ta + 359 + 2 * $urandom_range(0, 1)) % 360),
                                  rand_radius());
                default: add_pair(rand_theta(), rand_radius(), rand_theta(), rand_radius());
            endcase
        end
        n_queued = pair_queue.size();
    endtask

    // driver: present queued pairs, count and predict accepted items
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                exp_points.push_back(solve_intersection(s_tdata));
                n_accepted++;
                if (s_tdata[8:0] >= 360 || s_tdata[31:23] >= 360) n_wrapped++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                    s_tvalid <= 1'b0;
                end else if (pair_queue.size() != 0) begin
                    s_tdata  <= pair_queue.pop_front();
                    s_tvalid <= 1'b1;
                    if (quiet_s > 0) begin
                        quiet_s--;
                    end else if (pair_queue.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
                        gap_cnt = $urandom_range(1, 11);
                        quiet_s = $urandom_range(0, 40);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure, compare each output item with the oldest prediction
    always @(posedge aclk) begin
        isect_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                n_checked++;
                if (exp_points.size() == 0) begin
                    $display("%0t unexpected item: got x=%0d y=%0d par=%0b clip=%0b", $time,
                             $signed(m_tdata[31:0]), $signed(m_tdata[63:32]),
                             m_tuser[0], m_tuser[1]);
                    n_errors++;
                end else begin
                    want = exp_points.pop_front();
                    if (m_tdata[31:0] !== want.x) begin
                        $display("%0t point_x mismatch: expected %0d, got %0d", $time,
                                 want.x, $signed(m_tdata[31:0]));
                        n_errors++;
                    end
                    if (m_tdata[63:32] !== want.y) begin
                        $display("%0t point_y mismatch: expected %0d, got %0d", $time,
                                 want.y, $signed(m_tdata[63:32]));
                        n_errors++;
                    end
                    if (m_tuser[0] !== want.par) begin
                        $display("%0t parallel mismatch: expected %0b, got %0b", $time,
                                 want.par, m_tuser[0]);
                        n_errors++;
                    end
                    if (m_tuser[1] !== want.clip) begin
                        $display("%0t clipped mismatch: expected %0b, got %0b", $time,
                                 want.clip, m_tuser[1]);
                        n_errors++;
                    end
                    if (want.par) n_parallel++;
                    if (want.clip) n_clipped++;
                end
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
                m_tready <= 1'b0;
            end else if (quiet_m > 0 || pair_queue.size() <= CALM_TAIL) begin
                if (quiet_m > 0) quiet_m--;
                m_tready <= 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_cnt = $urandom_range(0, 10);
                quiet_m   = $urandom_range(0, 40);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // reset, stimulus and end of run
    initial begin
        build_sin_lut();
        fill_pairs();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        while (n_accepted < n_queued || exp_points.size() != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);
        $display("covered %0d line pairs: %0d parallel, %0d with angles past 359, %0d clipped",
                 n_checked, n_parallel, n_wrapped, n_clipped);
        if (n_errors == 0 && exp_points.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // timeout
    initial begin
        #2000000;
        $display("timeout with %0d items accepted, %0d results pending", n_accepted,
                 exp_points.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/pli_pkg.sv
rtl/core/pli_sine_lut.sv
rtl/core/pli_front.sv
rtl/core/pli_div_cell.sv
rtl/core/polar_line_intersect.sv
tb/tb_polar_line_intersect.sv
